[hw/rtl/tta_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tta_pkg: shared types and constants for the tensor transpose address gen
// Sizes, register indexes, queue entry and setup-to-datapath control bundle.
// ----------------------------------------------------------------------------
package tta_pkg;

   localparam int MAX_RANK        = 4;
   localparam int DIM_BITS        = 12;
   localparam int OFFSET_BITS     = 24;
   localparam int RANK_W          = $clog2(MAX_RANK);

   localparam int ELEM_W          = 32;
   localparam int SIZE_W          = 13;
   localparam int AXIS_W          = 8;
   localparam int AXIS_FIELD_BITS = 2;
   localparam int CSR_INDEX_W     = 3;
   localparam int CSR_DATA_W      = 13;

   localparam int COUNT_W         = OFFSET_BITS + 1;
   localparam int QUEUE_DEPTH     = 2;
   localparam int QUEUE_PTR_W     = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W     = $clog2(QUEUE_DEPTH + 1);

   // register indexes of the configuration port
   localparam logic [CSR_INDEX_W-1:0] REG_SIZE_DIM0  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_SIZE_DIM1  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_SIZE_DIM2  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_SIZE_DIM3  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_AXIS_ORDER = 3'd4;

   localparam logic [SIZE_W-1:0]  SIZE_RESET  = SIZE_W'(1);
   localparam logic [SIZE_W-1:0]  DIM_LIMIT   = SIZE_W'(1) << DIM_BITS;
   localparam logic [AXIS_W-1:0]  AXIS_RESET  = 8'd228;
   localparam logic [COUNT_W-1:0] COUNT_LIMIT = COUNT_W'(1) << OFFSET_BITS;

   typedef enum logic [2:0] {
      SET_START,
      SET_STRIDE,
      SET_MAP,
      SET_MUL,
      SET_ACC,
      SET_IDLE
   } setup_state_type;

   // derived configuration seen by the datapath
   typedef struct packed {
      logic [MAX_RANK-1:0][DIM_BITS-1:0]    dim_max;     // size - 1 per input axis
      logic [MAX_RANK-1:0][OFFSET_BITS-1:0] wrap_delta;  // offset step when digit k carries
      logic                                 cfg_error;
      logic                                 busy;
      logic                                 restart;
   } cfg_type;

   typedef struct packed {
      logic [ELEM_W-1:0] element;
      logic [RANK_W-1:0] carry_digit;
      logic              last;
   } entry_type;

endpackage

[hw/rtl/tta_setup.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tta_setup: configuration registers and derivation sequencer
// Holds sizes and axis order, derives output strides, carry deltas and error.
// ----------------------------------------------------------------------------
module tta_setup import tta_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output cfg_type                cfg
);

   logic [MAX_RANK-1:0][SIZE_W-1:0]      size_ff;
   logic [AXIS_W-1:0]                    axis_ff;

   setup_state_type                      state_ff, state_in;
   logic [RANK_W-1:0]                    k_ff, k_in;
   logic [OFFSET_BITS-1:0]               st_ff, st_in;
   logic [COUNT_W-1:0]                   count_ff, count_in;
   logic [MAX_RANK-1:0][OFFSET_BITS-1:0] out_stride_ff, out_stride_in;
   logic [MAX_RANK-1:0][OFFSET_BITS-1:0] in_str_ff, in_str_in;
   logic [MAX_RANK-1:0][OFFSET_BITS-1:0] delta_ff, delta_in;
   logic [OFFSET_BITS-1:0]               acc_ff, acc_in;
   logic [OFFSET_BITS-1:0]               prod_ff, prod_in;
   logic                                 err_ff, err_in;

   logic [MAX_RANK-1:0][SIZE_W-1:0]      eff;
   logic [MAX_RANK-1:0][DIM_BITS-1:0]    dim_max;
   logic [MAX_RANK-1:0][RANK_W-1:0]      src;
   logic                                 size_err;
   logic                                 perm_err;
   logic                                 cfg_write;
   logic [SIZE_W-1:0]                    out_dim;
   logic [OFFSET_BITS+SIZE_W-1:0]        stride_prod;
   logic [COUNT_W+SIZE_W-1:0]            count_prod;
   logic [OFFSET_BITS+DIM_BITS-1:0]      wrap_prod;

   assign csr_ready = 1'b1;

   always_comb begin
      case (csr_index)
         REG_SIZE_DIM0, REG_SIZE_DIM1, REG_SIZE_DIM2, REG_SIZE_DIM3,
         REG_AXIS_ORDER: cfg_write = csr_valid;
         default:        cfg_write = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_RANK; i++) begin
            size_ff[i] <= SIZE_RESET;
         end
         axis_ff <= AXIS_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_SIZE_DIM0:  size_ff[0] <= csr_data[SIZE_W-1:0];
            REG_SIZE_DIM1:  size_ff[1] <= csr_data[SIZE_W-1:0];
            REG_SIZE_DIM2:  size_ff[2] <= csr_data[SIZE_W-1:0];
            REG_SIZE_DIM3:  size_ff[3] <= csr_data[SIZE_W-1:0];
            REG_AXIS_ORDER: axis_ff    <= csr_data[AXIS_W-1:0];
            default: ;
         endcase
      end
   end

   // clamp sizes, check the axis order
   always_comb begin
      size_err = 1'b0;
      perm_err = 1'b0;
      for (int i = 0; i < MAX_RANK; i++) begin
         if (size_ff[i] == '0) begin
            eff[i]   = SIZE_W'(1);
            size_err = 1'b1;
         end else if (size_ff[i] > DIM_LIMIT) begin
            eff[i]   = DIM_LIMIT;
            size_err = 1'b1;
         end else begin
            eff[i] = size_ff[i];
         end
         dim_max[i] = DIM_BITS'(eff[i] - SIZE_W'(1));
         src[i]     = axis_ff[AXIS_FIELD_BITS*i +: AXIS_FIELD_BITS];
      end
      for (int j = 1; j < MAX_RANK; j++) begin
         for (int i = 0; i < j; i++) begin
            if (src[i] == src[j]) begin
               perm_err = 1'b1;
            end
         end
      end
   end

   assign out_dim     = eff[src[k_ff]];
   assign stride_prod = (OFFSET_BITS+SIZE_W)'(st_ff) * (OFFSET_BITS+SIZE_W)'(out_dim);
   assign count_prod  = (COUNT_W+SIZE_W)'(count_ff) * (COUNT_W+SIZE_W)'(eff[k_ff]);
   assign wrap_prod   = (OFFSET_BITS+DIM_BITS)'(in_str_ff[k_ff])
                        * (OFFSET_BITS+DIM_BITS)'(dim_max[k_ff]);

   always_comb begin
      state_in      = state_ff;
      k_in          = k_ff;
      st_in         = st_ff;
      count_in      = count_ff;
      out_stride_in = out_stride_ff;
      in_str_in     = in_str_ff;
      delta_in      = delta_ff;
      acc_in        = acc_ff;
      prod_in       = prod_ff;
      err_in        = err_ff;
      case (state_ff)
         SET_START: begin
            st_in    = OFFSET_BITS'(1);
            count_in = COUNT_W'(1);
            k_in     = RANK_W'(MAX_RANK - 1);
            state_in = SET_STRIDE;
         end
         SET_STRIDE: begin
            // suffix products of the permuted sizes, innermost first
            out_stride_in[k_ff] = st_ff;
            st_in               = stride_prod[OFFSET_BITS-1:0];
            if (count_prod > (COUNT_W+SIZE_W)'(COUNT_LIMIT)) begin
               count_in = COUNT_LIMIT + COUNT_W'(1);
            end else begin
               count_in = count_prod[COUNT_W-1:0];
            end
            if (k_ff == '0) begin
               state_in = SET_MAP;
            end else begin
               k_in = k_ff - RANK_W'(1);
            end
         end
         SET_MAP: begin
            // stride seen by each input axis
            for (int i = 0; i < MAX_RANK; i++) begin
               in_str_in[i] = '0;
               for (int j = 0; j < MAX_RANK; j++) begin
                  if (src[j] == RANK_W'(i)) begin
                     in_str_in[i] = out_stride_ff[j];
                  end
               end
            end
            err_in   = size_err | perm_err | (count_ff > COUNT_LIMIT);
            acc_in   = '0;
            k_in     = RANK_W'(MAX_RANK - 1);
            state_in = SET_MUL;
         end
         SET_MUL: begin
            // carry at k: add stride k, remove what the inner digits had built
            delta_in[k_ff] = in_str_ff[k_ff] - acc_ff;
            prod_in        = wrap_prod[OFFSET_BITS-1:0];
            if (k_ff == '0) begin
               state_in = SET_IDLE;
            end else begin
               state_in = SET_ACC;
            end
         end
         SET_ACC: begin
            acc_in   = acc_ff + prod_ff;
            k_in     = k_ff - RANK_W'(1);
            state_in = SET_MUL;
         end
         SET_IDLE: ;
         default: state_in = SET_START;
      endcase
      if (cfg_write) begin
         state_in = SET_START;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SET_START;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff          <= k_in;
      st_ff         <= st_in;
      count_ff      <= count_in;
      out_stride_ff <= out_stride_in;
      in_str_ff     <= in_str_in;
      delta_ff      <= delta_in;
      acc_ff        <= acc_in;
      prod_ff       <= prod_in;
      err_ff        <= err_in;
   end

   assign cfg.dim_max    = dim_max;
   assign cfg.wrap_delta = delta_ff;
   assign cfg.cfg_error  = err_ff;
   assign cfg.busy       = (state_ff != SET_IDLE);
   assign cfg.restart    = (state_ff == SET_START);

endmodule

[hw/rtl/tta_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tta_front: input index counter and item classification
// Tracks the mixed-radix input index and tags each element with its carry.
// ----------------------------------------------------------------------------
module tta_front import tta_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [ELEM_W-1:0] req_element,
   input  logic              q_room,
   output logic              push,
   output entry_type         push_entry
);

   logic [MAX_RANK-1:0][DIM_BITS-1:0] cnt_ff, cnt_in;
   logic [MAX_RANK-1:0]               at_max;
   logic [RANK_W-1:0]                 carry;
   logic                              last;

   assign req_ready = !cfg.busy && q_room;
   assign push      = req_valid && req_ready;

   always_comb begin
      carry = '0;
      for (int i = 0; i < MAX_RANK; i++) begin
         at_max[i] = (cnt_ff[i] == cfg.dim_max[i]);
         if (!at_max[i]) begin
            carry = RANK_W'(i);   // innermost digit that can still count up
         end
      end
      last = &at_max;
      for (int i = 0; i < MAX_RANK; i++) begin
         if (last || RANK_W'(i) > carry) begin
            cnt_in[i] = '0;
         end else if (RANK_W'(i) == carry) begin
            cnt_in[i] = cnt_ff[i] + DIM_BITS'(1);
         end else begin
            cnt_in[i] = cnt_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cfg.restart) begin
         cnt_ff <= '0;
      end else if (push) begin
         cnt_ff <= cnt_in;
      end
   end

   assign push_entry.element     = req_element;
   assign push_entry.carry_digit = carry;
   assign push_entry.last        = last;

endmodule

[hw/rtl/tta_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tta_queue: small FIFO between the front and back halves
// Two entries; lets the front keep accepting while the result register waits.
// ----------------------------------------------------------------------------
module tta_queue import tta_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   output logic      q_room,
   input  logic      pop,
   output logic      q_avail,
   output entry_type head
);

   entry_type                  mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_CNT_W-1:0]     count_ff;

   assign q_room  = (count_ff != QUEUE_CNT_W'(QUEUE_DEPTH));
   assign q_avail = (count_ff != '0);
   assign head    = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                         : wr_ptr_ff + QUEUE_PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                         : rd_ptr_ff + QUEUE_PTR_W'(1);
         end
         case ({push, pop})
            2'b10:   count_ff <= count_ff + QUEUE_CNT_W'(1);
            2'b01:   count_ff <= count_ff - QUEUE_CNT_W'(1);
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

[hw/rtl/tta_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tta_back: running output offset and result register
// Adds the carry delta per element and holds the result until taken.
// ----------------------------------------------------------------------------
module tta_back import tta_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  cfg_type                cfg,
   input  logic                   q_avail,
   input  entry_type              head,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [ELEM_W-1:0]      rsp_element_out,
   output logic [OFFSET_BITS-1:0] rsp_dest_offset,
   output logic                   rsp_last_element,
   output logic                   rsp_config_error
);

   logic                   rsp_valid_ff;
   logic [OFFSET_BITS-1:0] offset_ff, offset_in;
   logic [ELEM_W-1:0]      element_ff;
   logic [OFFSET_BITS-1:0] dest_ff;
   logic                   last_ff;
   logic                   err_ff;

   assign pop       = q_avail && (!rsp_valid_ff || rsp_ready);
   assign offset_in = head.last ? '0 : offset_ff + cfg.wrap_delta[head.carry_digit];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (pop) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cfg.restart) begin
         offset_ff <= '0;
      end else if (pop) begin
         offset_ff <= offset_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         element_ff <= head.element;
         dest_ff    <= cfg.cfg_error ? '0 : offset_ff;
         last_ff    <= head.last;
         err_ff     <= cfg.cfg_error;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_element_out  = element_ff;
   assign rsp_dest_offset  = dest_ff;
   assign rsp_last_element = last_ff;
   assign rsp_config_error = err_ff;

endmodule

[hw/rtl/tensor_transpose_address_gen.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tensor_transpose_address_gen: N-d tensor transpose address generator
// Streams elements in input row-major order and returns each with its
// row-major offset in the permuted output tensor.
// ----------------------------------------------------------------------------
//
//  channel | direction | ports                              | transfer
//  --------+-----------+------------------------------------+------------------
//  req     | in        | req_element                        | req_valid & req_ready
//  rsp     | out       | rsp_element_out, rsp_dest_offset,  | rsp_valid & rsp_ready
//          |           | rsp_last_element, rsp_config_error |
//  csr     | in        | csr_index, csr_data                | csr_valid & csr_ready
//
//  One element per cycle sustained while rsp is not stalled and setup is idle;
//  from req transfer to rsp valid: front counter -> queue -> result register.
//  After reset and after every write to a defined register the setup sequencer
//  runs (a start step, one multiply step per axis for strides and count, a
//  mapping step, then alternating multiply and accumulate steps for the carry
//  deltas); req_ready is low meanwhile. csr_ready is always high.
//  Stalls on rsp back up through the two-entry queue to req_ready.
//
module tensor_transpose_address_gen import tta_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [ELEM_W-1:0]      req_element,

   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [ELEM_W-1:0]      rsp_element_out,
   output logic [OFFSET_BITS-1:0] rsp_dest_offset,
   output logic                   rsp_last_element,
   output logic                   rsp_config_error,

   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   cfg_type   cfg;
   logic      push;
   entry_type push_entry;
   logic      q_room;
   logic      q_avail;
   logic      pop;
   entry_type head;

   // configuration registers; derives strides, carry deltas and error flag
   tta_setup u_setup (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // front: input index counter, tags each element with its carry digit
   tta_front u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_element (req_element),
      .q_room      (q_room),
      .push        (push),
      .push_entry  (push_entry)
   );

   // decoupling queue between the two halves
   tta_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .q_room     (q_room),
      .pop        (pop),
      .q_avail    (q_avail),
      .head       (head)
   );

   // back: running destination offset and result register
   tta_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .q_avail          (q_avail),
      .head             (head),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_element_out  (rsp_element_out),
      .rsp_dest_offset  (rsp_dest_offset),
      .rsp_last_element (rsp_last_element),
      .rsp_config_error (rsp_config_error)
   );

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for tensor_transpose_address_gen
// Streams elements through the block under random shapes and axis orders,
// predicts each output offset in step and checks every rsp transfer.
// ----------------------------------------------------------------------------
module tb;
   import tta_pkg::*;

   localparam int CLK_PERIOD   = 10;
   localparam int RANDOM_ITEMS = 760;
   localparam int DRAIN_LIMIT  = 5000;   // cycles to wait for outstanding results
   localparam int REG_COUNT    = 5;

   localparam bit [63:0] DIM_SPAN    = 64'(1) << DIM_BITS;
   localparam bit [63:0] OFF_SPAN    = 64'(1) << OFFSET_BITS;
   localparam bit [63:0] OFF_MASK    = OFF_SPAN - 64'(1);
   localparam bit [63:0] STRIDE_MASK = 64'hFFFF_FFFF_FFFF;

   // axis orders: source axis of output axis j sits in bits 2j+1..2j
   localparam logic [AXIS_W-1:0] ORDER_IDENTITY   = AXIS_RESET;
   localparam logic [AXIS_W-1:0] ORDER_SWAP_INNER = 8'hB4;  // 0,1,3,2
   localparam logic [AXIS_W-1:0] ORDER_REVERSE    = 8'h1B;  // 3,2,1,0
   localparam logic [AXIS_W-1:0] ORDER_ROTATE     = 8'h4E;  // 2,3,0,1
   localparam logic [AXIS_W-1:0] ORDER_ALL_ZERO   = 8'h00;  // not a permutation

   typedef struct {
      logic [ELEM_W-1:0]      element;
      logic [OFFSET_BITS-1:0] offset;
      logic                   last;
      logic                   cfg_err;
   } placement_type;

   // ------------------------------------------------------------------------
   // DUT ports; every input is known from time zero
   // ------------------------------------------------------------------------
   logic                   clock       = 1'b0;
   logic                   reset       = 1'b1;
   logic                   req_valid   = 1'b0;
   logic                   req_ready;
   logic [ELEM_W-1:0]      req_element = '0;
   logic                   rsp_valid;
   logic                   rsp_ready   = 1'b0;
   logic [ELEM_W-1:0]      rsp_element_out;
   logic [OFFSET_BITS-1:0] rsp_dest_offset;
   logic                   rsp_last_element;
   logic                   rsp_config_error;
   logic                   csr_valid   = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index   = '0;
   logic [CSR_DATA_W-1:0]  csr_data    = '0;

   tensor_transpose_address_gen u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_element      (req_element),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_element_out  (rsp_element_out),
      .rsp_dest_offset  (rsp_dest_offset),
      .rsp_last_element (rsp_last_element),
      .rsp_config_error (rsp_config_error),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   // ------------------------------------------------------------------------
   // Predictor state: registers plus the derived layout and index digits
   // ------------------------------------------------------------------------
   logic [SIZE_W-1:0] shape_reg [MAX_RANK];
   logic [AXIS_W-1:0] order_reg;
   bit   [63:0]       extent    [MAX_RANK];  // clamped size per input axis
   bit   [63:0]       stride    [MAX_RANK];  // per output axis
   bit   [63:0]       digit     [MAX_RANK];  // input index, one digit per axis
   int                src_axis  [MAX_RANK];
   bit                layout_bad;

   placement_type placement_q [$];   // expected results, oldest first
   int            fail_count   = 0;

   // stimulus knobs shared by the test tasks, the sender gap picker and the receiver
   bit no_idle      = 1'b0;   // neither side idles
   bit burst_mode   = 1'b0;   // sender only: back-to-back transfers
   int hold_request = 0;      // receiver: one long hold-off of this many cycles
   int stall_left   = 0;

   // Recompute clamped sizes, strides and the error flag; a write to a defined
   // register also sends the index counter back to the first element.
   function automatic void rebuild_layout();
      bit [63:0] dim_out [MAX_RANK];
      bit        taken   [MAX_RANK];
      bit [63:0] raw;
      bit [63:0] span;
      bit [63:0] total;
      layout_bad = 1'b0;
      for (int j = 0; j < MAX_RANK; j++) begin
         raw = 64'(shape_reg[j]);
         if (raw == 0) begin
            // zero size: flagged, walked as size 1
            layout_bad = 1'b1;
            raw = 64'(1);
         end else if (raw > DIM_SPAN) begin
            // oversize: flagged, walked as the largest legal size
            layout_bad = 1'b1;
            raw = DIM_SPAN;
         end
         extent[j] = raw;
         taken[j]  = 1'b0;
      end
      for (int j = 0; j < MAX_RANK; j++) begin
         src_axis[j] = int'(order_reg[2*j +: 2]);
         if (taken[src_axis[j]]) layout_bad = 1'b1;
         else taken[src_axis[j]] = 1'b1;
      end
      for (int j = 0; j < MAX_RANK; j++) dim_out[j] = extent[src_axis[j]];
      // strides are suffix products of the permuted sizes
      span = 64'(1);
      for (int k = MAX_RANK - 1; k >= 0; k--) begin
         stride[k] = span & OFF_MASK;
         span = (span * dim_out[k]) & STRIDE_MASK;
      end
      // element count above the offset range is an error
      total = 64'(1);
      for (int j = 0; j < MAX_RANK; j++) begin
         if (total > OFF_SPAN) break;
         total = total * extent[j];
      end
      if (total > OFF_SPAN) layout_bad = 1'b1;
      for (int j = 0; j < MAX_RANK; j++) digit[j] = 64'(0);
   endfunction

   function automatic void apply_reg_write(input logic [CSR_INDEX_W-1:0] idx,
                                           input logic [CSR_DATA_W-1:0]  data);
      if (idx <= REG_SIZE_DIM3) begin
         shape_reg[idx] = data[SIZE_W-1:0];
         rebuild_layout();
      end else if (idx == REG_AXIS_ORDER) begin
         order_reg = data[AXIS_W-1:0];
         rebuild_layout();
      end
      // unknown indexes leave everything untouched, counter included
   endfunction

   // Expected result for one accepted element, then step the mixed-radix counter.
   function automatic void place_element(input logic [ELEM_W-1:0] value);
      bit [63:0]     off;
      bit            at_end;
      placement_type p;
      off    = 64'(0);
      at_end = 1'b1;
      for (int j = 0; j < MAX_RANK; j++) begin
         off = (off + stride[j] * digit[src_axis[j]]) & OFF_MASK;
         if (digit[j] + 64'(1) != extent[j]) at_end = 1'b0;
      end
      p.element = value;
      p.offset  = layout_bad ? '0 : off[OFFSET_BITS-1:0];
      p.last    = at_end;
      p.cfg_err = layout_bad;
      placement_q.push_back(p);
      // innermost digit first; wraps to zero after the last element
      for (int k = MAX_RANK - 1; k >= 0; k--) begin
         if (digit[k] + 64'(1) < extent[k]) begin
            digit[k]++;
            break;
         end
         digit[k] = 64'(0);
      end
   endfunction

   // ------------------------------------------------------------------------
   // Clock, timeout
   // ------------------------------------------------------------------------
   initial begin
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   // well above the slowest legal run
   initial begin
      #5_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Receiver: random rsp_ready, plus one long hold-off on request
   // ------------------------------------------------------------------------
   initial begin
      int r;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else if (hold_request > 0) begin
            rsp_ready <= 1'b0;
            stall_left   = hold_request - 1;
            hold_request = 0;
         end else if (no_idle) begin
            rsp_ready <= 1'b1;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
               rsp_ready <= 1'b1;
            end else if (r < 93) begin
               rsp_ready <= 1'b0;
               stall_left = $urandom_range(0, 2);
            end else begin
               rsp_ready <= 1'b0;
               stall_left = $urandom_range(8, 40);
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Result checker: each rsp transfer against the oldest expectation
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : check_results
      placement_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (placement_q.size() == 0) begin
            $error("rsp transfer with no expected result (element %h)", rsp_element_out);
            fail_count++;
         end else begin
            want = placement_q.pop_front();
            if (rsp_element_out !== want.element) begin
               $error("element_out: expected %h, actual %h", want.element, rsp_element_out);
               fail_count++;
            end
            if (rsp_dest_offset !== want.offset) begin
               $error("dest_offset: expected %0d, actual %0d", want.offset, rsp_dest_offset);
               fail_count++;
            end
            if (rsp_last_element !== want.last) begin
               $error("last_element: expected %0b, actual %0b", want.last, rsp_last_element);
               fail_count++;
            end
            if (rsp_config_error !== want.cfg_err) begin
               $error("config_error: expected %0b, actual %0b", want.cfg_err,
                      rsp_config_error);
               fail_count++;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Sender side
   // ------------------------------------------------------------------------
   // mostly no gap, some short ones, a few long ones
   function automatic int pick_gap();
      int r;
      if (no_idle || burst_mode) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // One element transfer on req; valid stays up across back-to-back items.
   task automatic send_element(input logic [ELEM_W-1:0] value);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid   <= 1'b1;
      req_element <= value;
      do @(posedge clock); while (!req_ready);
      place_element(value);
   endtask

   // Stop offering and wait until every expected result has come back.
   task automatic wait_drain();
      int waited;
      @(negedge clock);
      req_valid <= 1'b0;
      waited = 0;
      while (placement_q.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (placement_q.size() != 0) begin
         $error("%0d expected results never arrived", placement_q.size());
         fail_count++;
         placement_q.delete();
      end
   endtask

   // Register write; callers drain first so the block is idle.
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0]  data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      apply_reg_write(idx, data);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_shape(input int d0, input int d1, input int d2, input int d3,
                            input logic [AXIS_W-1:0] order);
      wait_drain();
      write_reg(REG_SIZE_DIM0, CSR_DATA_W'(d0));
      write_reg(REG_SIZE_DIM1, CSR_DATA_W'(d1));
      write_reg(REG_SIZE_DIM2, CSR_DATA_W'(d2));
      write_reg(REG_SIZE_DIM3, CSR_DATA_W'(d3));
      write_reg(REG_AXIS_ORDER, CSR_DATA_W'(order));
   endtask

   // unknown register index: 5..7
   function automatic logic [CSR_INDEX_W-1:0] unused_index();
      return CSR_INDEX_W'($urandom_range(int'(REG_AXIS_ORDER) + 1, (1 << CSR_INDEX_W) - 1));
   endfunction

   // size register value: mostly tiny, sometimes large, rarely out of range
   function automatic logic [CSR_DATA_W-1:0] pick_size();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return CSR_DATA_W'($urandom_range(1, 4));
      if (r < 75) return CSR_DATA_W'(1);
      if (r < 90) return CSR_DATA_W'($urandom_range(5, 12));
      if (r < 95) return CSR_DATA_W'($urandom_range(13, int'(DIM_SPAN)));
      if (r < 98) return '0;
      return CSR_DATA_W'($urandom_range(int'(DIM_SPAN) + 1, (1 << CSR_DATA_W) - 1));
   endfunction

   // axis order: mostly a true permutation; unused upper data bits random
   function automatic logic [CSR_DATA_W-1:0] pick_order();
      int                axes [MAX_RANK];
      int                k;
      int                tmp;
      logic [AXIS_W-1:0] packed_order;
      if ($urandom_range(0, 4) == 0) begin
         packed_order = AXIS_W'($urandom);
      end else begin
         for (int j = 0; j < MAX_RANK; j++) axes[j] = j;
         for (int j = MAX_RANK - 1; j > 0; j--) begin
            k       = $urandom_range(0, j);
            tmp     = axes[j];
            axes[j] = axes[k];
            axes[k] = tmp;
         end
         for (int j = 0; j < MAX_RANK; j++) packed_order[2*j +: 2] = 2'(axes[j]);
      end
      return {(CSR_DATA_W - AXIS_W)'($urandom), packed_order};
   endfunction

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------
   // Reset shape is a single element: offset 0, last on every element.
   task automatic test_reset_state();
      send_element(32'h0000_0000);
      send_element(32'hFFFF_FFFF);
      send_element(32'hAAAA_AAAA);
      send_element(32'h5555_5555);
   endtask

   task automatic test_directed_cases();
      // 2x3 inner block with the two inner axes swapped, one full pass
      set_shape(1, 1, 2, 3, ORDER_SWAP_INNER);
      repeat (6) send_element($urandom);
      // unknown indexes mid-tensor must not restart the counter
      repeat (2) send_element($urandom);
      wait_drain();
      for (int i = int'(REG_AXIS_ORDER) + 1; i < (1 << CSR_INDEX_W); i++)
         write_reg(CSR_INDEX_W'(i), CSR_DATA_W'($urandom));
      repeat (4) send_element($urandom);
      // order with a repeated source axis
      wait_drain();
      write_reg(REG_AXIS_ORDER, CSR_DATA_W'(ORDER_ALL_ZERO));
      send_element($urandom);
      wait_drain();
      write_reg(REG_AXIS_ORDER, CSR_DATA_W'(ORDER_IDENTITY));
      // zero size, then the largest register value
      wait_drain();
      write_reg(REG_SIZE_DIM0, '0);
      send_element($urandom);
      wait_drain();
      write_reg(REG_SIZE_DIM0, '1);
      send_element($urandom);
      // element count twice the offset range
      set_shape(int'(DIM_SPAN), int'(DIM_SPAN), 2, 1, ORDER_IDENTITY);
      send_element($urandom);
      // exactly at the range, reversed so strides are large
      set_shape(int'(DIM_SPAN), int'(DIM_SPAN), 1, 1, ORDER_REVERSE);
      repeat (2) send_element($urandom);
   endtask

   task automatic test_random_tensors();
      int                     sent;
      int                     n;
      int                     first;
      int                     part;
      bit [63:0]              total;
      logic [CSR_INDEX_W-1:0] idx;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         wait_drain();
         no_idle = ($urandom_range(0, 9) == 0);
         if ($urandom_range(0, 7) == 0) write_reg(unused_index(), CSR_DATA_W'($urandom));
         if ($urandom_range(0, 3) == 0) begin
            // touch one register only
            idx = CSR_INDEX_W'($urandom_range(0, REG_COUNT - 1));
            write_reg(idx, (idx == REG_AXIS_ORDER) ? pick_order() : pick_size());
         end else begin
            first = $urandom_range(0, REG_COUNT - 1);
            for (int i = 0; i < REG_COUNT; i++) begin
               idx = CSR_INDEX_W'((first + i) % REG_COUNT);
               write_reg(idx, (idx == REG_AXIS_ORDER) ? pick_order() : pick_size());
            end
         end
         // small tensors get one or two full passes so the wrap is seen
         total = 64'(1);
         for (int j = 0; j < MAX_RANK; j++) total = total * extent[j];
         if (total <= 64'(48)) n = int'(total) * $urandom_range(1, 2) + $urandom_range(0, 2);
         else n = $urandom_range(4, 40);
         if ($urandom_range(0, 5) == 0) begin
            // split the pass around a write to an unknown index
            part = n / 2;
            repeat (part) send_element($urandom);
            wait_drain();
            write_reg(unused_index(), CSR_DATA_W'($urandom));
            repeat (n - part) send_element($urandom);
         end else begin
            repeat (n) send_element($urandom);
         end
         sent += n;
      end
      no_idle = 1'b0;
   endtask

   // Receiver holds off while the sender keeps offering, so req_ready drops;
   // then the sender pauses until every result is back.
   task automatic test_backpressure();
      set_shape(4, 2, 3, 1, ORDER_ROTATE);
      hold_request = 80;
      burst_mode   = 1'b1;
      repeat (30) send_element($urandom);
      burst_mode   = 1'b0;
      wait_drain();
      repeat (12) send_element($urandom);
   endtask

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin
      for (int j = 0; j < MAX_RANK; j++) shape_reg[j] = SIZE_RESET;
      order_reg = AXIS_RESET;
      rebuild_layout();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_directed_cases();
      test_backpressure();
      test_random_tensors();

      wait_drain();
      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

[filelist.f]
hw/rtl/tta_pkg.sv
hw/rtl/tta_setup.sv
hw/rtl/tta_front.sv
hw/rtl/tta_queue.sv
hw/rtl/tta_back.sv
hw/rtl/tensor_transpose_address_gen.sv
dv/tb.sv
